>>> src/btlv_pkg.sv
// ----------------------------------------------------------------------------
// btlv_pkg: shared types and constants for the BER header parser
// Decode phases, status codes, result record and size constants.
// ----------------------------------------------------------------------------
package btlv_pkg;

   localparam int MAX_LENGTH_OCTETS = 4;
   localparam int MAX_TAG_OCTETS    = 4;

   localparam int TAG_CNT_W = $clog2(MAX_TAG_OCTETS + 1);
   localparam int LEN_CNT_W = $clog2(MAX_LENGTH_OCTETS + 1);

   localparam int TAG_W     = 28;
   localparam int LEN_W     = 32;
   localparam int OCTET_W   = 4;
   localparam int REQ_W     = 8;
   localparam int RSP_W     = 72;  // 71 field bits, padded to whole bytes

   localparam logic [7:0] LEN_INDEF     = 8'h80;
   localparam logic [4:0] TAG_LONG_FORM = 5'h1f;

   typedef enum logic [2:0] {
      PH_IDENT = 3'd0,
      PH_EOC2  = 3'd1,
      PH_TAGX  = 3'd2,
      PH_LEN1  = 3'd3,
      PH_LENN  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_BAD_EOC     = 2'd1,
      ST_LEN_TOO_LONG = 2'd2,
      ST_TAG_TOO_LONG = 2'd3
   } status_type;

   typedef struct packed {
      status_type           status;
      logic [OCTET_W-1:0]   header_octets;
      logic                 end_of_contents;
      logic                 indefinite;
      logic [LEN_W-1:0]     content_length;
      logic [TAG_W-1:0]     tag_number;
      logic                 constructed;
      logic [1:0]           id_class;
   } rsp_type;

endpackage

>>> src/ber_tlv_header_parser.sv
// ----------------------------------------------------------------------------
// ber_tlv_header_parser: BER identifier and length header decoder
// Takes one header octet per item and gives one item per finished header or
// error, carrying class, form, tag number, length, flags, octet count, status.
// ----------------------------------------------------------------------------
//
//  channel  direction  tdata bits  contents
//  req_     in         8           one raw header octet
//  rsp_     out        72          decoded header record (see rsp_tdata)
//
// One octet per cycle sustained while the result side does not stall: an octet
// waits in the input register while the decoder updates its state and, when a
// header ends, loads the result register. The octet ending a header passes
// through the input register, then the result register holds its decoded header.
// Reset is synchronous; afterwards the parser waits for an identifier octet.
// A stalled result holds the decoder; the input register still takes one
// octet, then req_tready drops until the result drains.
//
module ber_tlv_header_parser
   import btlv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // [7:0] data_byte
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // [1:0] id_class, [2] constructed,
                                         // [30:3] tag_number,
                                         // [62:31] content_length,
                                         // [63] indefinite, [64] end_of_contents,
                                         // [68:65] header_octets, [70:69] status,
                                         // [71] zero
);

   logic       item_valid;
   logic [7:0] item_byte;
   logic       can_load;
   logic       advance;
   logic       done;
   rsp_type    result;

   // decoder steps only when the result register can take whatever it makes
   assign advance = item_valid && can_load;

   btlv_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (advance),
      .item_valid (item_valid),
      .item_byte  (item_byte)
   );

   btlv_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .data_byte (item_byte),
      .done      (done),
      .result    (result)
   );

   btlv_result_stage u_result (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && done),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   rsp_type rsp_view;
   assign rsp_view = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);

   // a header spans at least identifier plus one more octet, at most ten
   a_octet_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_view.header_octets >= 4'd2 && rsp_view.header_octets <= 4'd10))
      else $error("header octet count out of range");

   // end-of-contents marker is always exactly two octets and ok
   a_eoc_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_view.end_of_contents |->
         (rsp_view.header_octets == 4'd2 && rsp_view.status == ST_OK
          && rsp_view.tag_number == '0))
      else $error("malformed end-of-contents item");

   // indefinite length carries no definite length
   a_indef_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_view.indefinite |-> rsp_view.content_length == '0)
      else $error("indefinite item with nonzero length");

   // tag overflow is reported on the last allowed extension octet if bit 7 is still set
   a_tag_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_view.status == ST_TAG_TOO_LONG |->
         (rsp_view.tag_number == '0
          && rsp_view.header_octets == OCTET_W'(MAX_TAG_OCTETS + 1)))
      else $error("tag overflow item malformed");

   // an octet waiting on a stalled result stays in the input register
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      item_valid && !advance |=> item_valid && $stable(item_byte))
      else $error("pending octet lost");
`endif

endmodule

>>> src/btlv_input_stage.sv
// ----------------------------------------------------------------------------
// btlv_input_stage: input register
// Holds one header octet until the decoder takes it.
// ----------------------------------------------------------------------------
module btlv_input_stage
   import btlv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             take,
   output logic             item_valid,
   output logic [7:0]       item_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;
   assign valid_in   = accept || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_tdata;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

>>> src/btlv_decoder.sv
// ----------------------------------------------------------------------------
// btlv_decoder: identifier and length decode state machine
// Updates the header state for one octet and forms the result when done.
// ----------------------------------------------------------------------------
module btlv_decoder
   import btlv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] data_byte,
   output logic       done,
   output rsp_type    result
);

   phase_type            phase_ff, phase_in;
   logic [1:0]           class_ff, class_in;
   logic                 form_ff, form_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic [TAG_CNT_W-1:0] tag_cnt_ff, tag_cnt_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [LEN_CNT_W-1:0] left_ff, left_in;
   logic [OCTET_W-1:0]   count_ff, count_in;

   logic [TAG_CNT_W-1:0] tag_cnt_inc;
   logic [LEN_CNT_W-1:0] left_dec;
   logic [6:0]           len_octets;
   logic                 tag_full;
   logic                 len_too_long;

   assign tag_cnt_inc  = tag_cnt_ff + 1'b1;
   assign tag_full     = tag_cnt_inc >= TAG_CNT_W'(MAX_TAG_OCTETS);
   assign left_dec     = (left_ff != '0) ? left_ff - 1'b1 : left_ff;
   assign len_octets   = data_byte[6:0];
   assign len_too_long = len_octets > 7'(MAX_LENGTH_OCTETS);

   // next phase
   always_comb begin
      case (phase_ff)
         PH_EOC2: phase_in = PH_IDENT;
         PH_TAGX: begin
            if (!data_byte[7]) begin
               phase_in = PH_LEN1;
            end else if (tag_full) begin
               phase_in = PH_IDENT;
            end else begin
               phase_in = PH_TAGX;
            end
         end
         PH_LEN1: begin
            if (!data_byte[7] || data_byte == LEN_INDEF || len_too_long) begin
               phase_in = PH_IDENT;
            end else begin
               phase_in = PH_LENN;
            end
         end
         PH_LENN: phase_in = (left_dec == '0) ? PH_IDENT : PH_LENN;
         default: begin
            if (data_byte == 8'h00) begin
               phase_in = PH_EOC2;
            end else if (data_byte[4:0] == TAG_LONG_FORM) begin
               phase_in = PH_TAGX;
            end else begin
               phase_in = PH_LEN1;
            end
         end
      endcase
   end

   // datapath and result
   always_comb begin
      class_in   = class_ff;
      form_in    = form_ff;
      tag_in     = tag_ff;
      tag_cnt_in = tag_cnt_ff;
      len_in     = len_ff;
      left_in    = left_ff;
      count_in   = count_ff + 1'b1;
      done       = 1'b0;

      result                 = '0;
      result.id_class        = class_ff;
      result.constructed     = form_ff;
      result.tag_number      = tag_ff;
      result.header_octets   = count_in;
      result.status          = ST_OK;

      case (phase_ff)
         PH_EOC2: begin
            done                   = 1'b1;
            result.id_class        = 2'b00;
            result.constructed     = 1'b0;
            result.tag_number      = '0;
            result.end_of_contents = (data_byte == 8'h00);
            result.status          = (data_byte == 8'h00) ? ST_OK : ST_BAD_EOC;
         end
         PH_TAGX: begin
            tag_cnt_in = tag_cnt_inc;
            tag_in     = {tag_ff[TAG_W-8:0], data_byte[6:0]};
            if (data_byte[7] && tag_full) begin
               done              = 1'b1;
               result.tag_number = '0;
               result.status     = ST_TAG_TOO_LONG;
            end
         end
         PH_LEN1: begin
            if (!data_byte[7]) begin
               done                  = 1'b1;
               result.content_length = LEN_W'(data_byte);
            end else if (data_byte == LEN_INDEF) begin
               done              = 1'b1;
               result.indefinite = 1'b1;
            end else if (len_too_long) begin
               done          = 1'b1;
               result.status = ST_LEN_TOO_LONG;
            end else begin
               len_in  = '0;
               left_in = len_octets[LEN_CNT_W-1:0];
            end
         end
         PH_LENN: begin
            len_in  = {len_ff[LEN_W-9:0], data_byte};
            left_in = left_dec;
            if (left_dec == '0) begin
               done                  = 1'b1;
               result.content_length = len_in;
            end
         end
         default: begin
            count_in   = OCTET_W'(1);
            tag_cnt_in = '0;
            len_in     = '0;
            left_in    = '0;
            if (data_byte == 8'h00) begin
               class_in = 2'b00;
               form_in  = 1'b0;
               tag_in   = '0;
            end else begin
               class_in = data_byte[7:6];
               form_in  = data_byte[5];
               tag_in   = (data_byte[4:0] == TAG_LONG_FORM) ? '0 : TAG_W'(data_byte[4:0]);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDENT;
         class_ff   <= '0;
         form_ff    <= 1'b0;
         tag_ff     <= '0;
         tag_cnt_ff <= '0;
         len_ff     <= '0;
         left_ff    <= '0;
         count_ff   <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         class_ff   <= class_in;
         form_ff    <= form_in;
         tag_ff     <= tag_in;
         tag_cnt_ff <= tag_cnt_in;
         len_ff     <= len_in;
         left_ff    <= left_in;
         count_ff   <= count_in;
      end
   end

endmodule

>>> src/btlv_result_stage.sv
// ----------------------------------------------------------------------------
// btlv_result_stage: result register
// Holds one decoded header until the sink takes it.
// ----------------------------------------------------------------------------
module btlv_result_stage
   import btlv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  rsp_type          result,
   output logic             can_load,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign can_load = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_W - $bits(rsp_type)){1'b0}}, data_ff};

endmodule

>>> bench/ber_header_checker.sv
// ----------------------------------------------------------------------------
// ber_header_checker: predictor and result checker for the BER header parser
// Watches both channels, decodes every accepted octet on its own and compares
// each accepted result with the oldest decoded header still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ber_header_checker
   import btlv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // [7:0] data_byte
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,   // record fields from bit 0, see rsp_type
   output int               fail_count,
   output int               pending_count,
   output int               rsp_count,
   output int               err_count
);

   // decoder state
   phase_type   ph;
   logic [1:0]  cls_q;
   logic        form_q;
   logic [27:0] tag_acc;
   int          tag_cnt;
   logic [31:0] len_acc;
   int          len_left;
   int          oct_cnt;

   rsp_type     expected_headers [$];

   // one octet through the decoder; done is set when a header or error ends
   task automatic decode_octet(input logic [7:0] b, output bit done,
                               output rsp_type hdr);
      done = 1'b0;
      hdr  = '0;
      if (oct_cnt < 255) oct_cnt++;
      case (ph)
         PH_EOC2: begin
            done = 1'b1;
            hdr.end_of_contents = (b == 8'h00);
            hdr.status = (b == 8'h00) ? ST_OK : ST_BAD_EOC;
         end
         PH_TAGX: begin
            tag_cnt++;
            tag_acc = {tag_acc[20:0], b[6:0]};
            if (!b[7]) begin
               ph = PH_LEN1;
            end else if (tag_cnt >= MAX_TAG_OCTETS) begin
               done = 1'b1;
               hdr.id_class    = cls_q;
               hdr.constructed = form_q;
               hdr.status      = ST_TAG_TOO_LONG;
            end
         end
         PH_LEN1: begin
            hdr.id_class    = cls_q;
            hdr.constructed = form_q;
            hdr.tag_number  = tag_acc;
            if (!b[7]) begin
               done = 1'b1;
               hdr.content_length = {24'd0, b};
            end else if (b == LEN_INDEF) begin
               done = 1'b1;
               hdr.indefinite = 1'b1;
            end else if (int'(b[6:0]) > MAX_LENGTH_OCTETS) begin
               done = 1'b1;
               hdr.status = ST_LEN_TOO_LONG;
            end else begin
               len_acc  = '0;
               len_left = int'(b[6:0]);
               ph       = PH_LENN;
            end
         end
         PH_LENN: begin
            len_acc = {len_acc[23:0], b};
            if (len_left > 0) len_left--;
            if (len_left == 0) begin
               done = 1'b1;
               hdr.id_class       = cls_q;
               hdr.constructed    = form_q;
               hdr.tag_number     = tag_acc;
               hdr.content_length = len_acc;
            end
         end
         default: begin
            // identifier octet; an unused phase code lands here as well
            oct_cnt  = 1;
            tag_cnt  = 0;
            len_acc  = '0;
            len_left = 0;
            cls_q    = b[7:6];
            form_q   = b[5];
            tag_acc  = '0;
            if (b == 8'h00) ph = PH_EOC2;
            else if (b[4:0] == TAG_LONG_FORM) ph = PH_TAGX;
            else begin
               tag_acc = {23'd0, b[4:0]};
               ph      = PH_LEN1;
            end
         end
      endcase
      if (done) begin
         hdr.header_octets = oct_cnt[3:0];
         ph = PH_IDENT;
      end
   endtask

   always @(posedge clock) begin
      bit      got;
      rsp_type hdr;
      rsp_type act;
      rsp_type exp;
      if (reset) begin
         ph         = PH_IDENT;
         cls_q      = '0;
         form_q     = 1'b0;
         tag_acc    = '0;
         tag_cnt    = 0;
         len_acc    = '0;
         len_left   = 0;
         oct_cnt    = 0;
         fail_count = 0;
         rsp_count  = 0;
         err_count  = 0;
         expected_headers.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            act = rsp_tdata[RSP_W-2:0];
            rsp_count++;
            if (act.status != ST_OK) err_count++;
            if (expected_headers.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result with nothing expected: tag=%h len=%h st=%0d",
                           $realtime, act.tag_number, act.content_length, act.status);
            end else begin
               exp = expected_headers.pop_front();
               if (act.id_class !== exp.id_class || act.constructed !== exp.constructed ||
                   act.tag_number !== exp.tag_number ||
                   act.content_length !== exp.content_length ||
                   act.indefinite !== exp.indefinite ||
                   act.end_of_contents !== exp.end_of_contents ||
                   act.header_octets !== exp.header_octets || act.status !== exp.status) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: mismatch", $realtime);
                     $display("  exp cls=%0d con=%0d tag=%h len=%h ind=%0d eoc=%0d oct=%0d st=%0d",
                              exp.id_class, exp.constructed, exp.tag_number,
                              exp.content_length, exp.indefinite, exp.end_of_contents,
                              exp.header_octets, exp.status);
                     $display("  got cls=%0d con=%0d tag=%h len=%h ind=%0d eoc=%0d oct=%0d st=%0d",
                              act.id_class, act.constructed, act.tag_number,
                              act.content_length, act.indefinite, act.end_of_contents,
                              act.header_octets, act.status);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            decode_octet(req_tdata, got, hdr);
            if (got) expected_headers.push_back(hdr);
         end
      end
      pending_count = expected_headers.size();
   end

endmodule

>>> bench/ber_tlv_header_parser_tb.sv
// ----------------------------------------------------------------------------
// ber_tlv_header_parser_tb: stream test of the BER header parser
// Feeds hand-picked headers, then random headers (a few malformed) mixed with noise
// octets, under random idling on both channels and one long result stall.
// A separate checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ber_tlv_header_parser_tb;
   import btlv_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int TOTAL_OCTETS = 1650;
   localparam int SECTION_LEN  = 200;   // octets per idling mode
   localparam int HOLD_CYCLES  = 300;   // long result stall
   localparam int HOLD_AT      = 800;   // octet count that triggers the stall
   localparam int IDLE_LIMIT   = 1000;  // watchdog: cycles with no item moving
   localparam int DRAIN_CYCLES = 16;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   int fail_count;
   int pending_count;
   int rsp_count;
   int err_count;

   // idling bounds, changed per section; 0 gives back-to-back items
   int req_gap_max = 10;
   int rsp_gap_max = 10;
   bit hold_rsp    = 1'b0;
   int octets_sent = 0;
   int idle_cycles = 0;

   logic [7:0] hdr_bytes [$];

   always #(HALF_PERIOD) clock = ~clock;

   ber_tlv_header_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ber_header_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .rsp_count     (rsp_count),
      .err_count     (err_count)
   );

   // Send one octet: random gap with valid low, then hold valid until taken.
   // Valid is only lowered when a gap is drawn, so back-to-back items keep it
   // high without a second assignment in the same step.
   task automatic send_octet(input logic [7:0] b);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      octets_sent++;
   endtask

   // Queue one random header. Mostly well-formed: end-of-contents markers,
   // short and long tags, and all length forms; a few deliberate errors.
   task automatic push_header();
      int         kind;
      int         cnt;
      int         i;
      logic [7:0] b;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         // end-of-contents marker
         hdr_bytes.push_back(8'h00);
         hdr_bytes.push_back(8'h00);
         return;
      end
      if (kind < 12) begin
         // broken marker: nonzero second octet
         b = 8'($urandom_range(1, 255));
         hdr_bytes.push_back(8'h00);
         hdr_bytes.push_back(b);
         return;
      end
      b = 8'($urandom);
      if (kind < 45) begin
         // long-form tag
         b[4:0] = TAG_LONG_FORM;
         hdr_bytes.push_back(b);
         if ($urandom_range(0, 9) == 0) begin
            // tag too long: every extension octet keeps bit 7 set
            for (i = 0; i < MAX_TAG_OCTETS; i++) begin
               b = 8'($urandom);
               b[7] = 1'b1;
               hdr_bytes.push_back(b);
            end
            return;
         end
         cnt = $urandom_range(1, MAX_TAG_OCTETS);
         for (i = 0; i < cnt; i++) begin
            b = 8'($urandom);
            b[7] = (i != cnt - 1);
            hdr_bytes.push_back(b);
         end
      end else begin
         b[4:0] = 5'($urandom_range(0, 30));
         if (b == 8'h00) b = 8'h02;  // keep it a real header, not a marker
         hdr_bytes.push_back(b);
      end
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         hdr_bytes.push_back(8'($urandom_range(0, 127)));
      end else if (kind < 55) begin
         hdr_bytes.push_back(LEN_INDEF);
      end else if (kind < 90) begin
         cnt = $urandom_range(1, MAX_LENGTH_OCTETS);
         hdr_bytes.push_back(LEN_INDEF | 8'(cnt));
         for (i = 0; i < cnt; i++) hdr_bytes.push_back(8'($urandom));
      end else begin
         // length octet count beyond the limit
         hdr_bytes.push_back(LEN_INDEF | 8'($urandom_range(MAX_LENGTH_OCTETS + 1, 127)));
      end
   endtask

   // Result side: random stall before each item, plus one long hold-off
   // requested by the stimulus while the sender keeps going.
   initial begin
      int w;
      bit hold_taken;
      hold_taken = 1'b0;
      wait (!reset);
      forever begin
         if (hold_rsp && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         w = $urandom_range(0, rsp_gap_max);
         if (w > 0) begin
            rsp_tready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Watchdog: ends the run if no item moves on either channel for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles, %0d results pending",
                     IDLE_LIMIT, pending_count);
            $display("== FAIL ==");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      bit hold_done;
      int sec;
      int i;
      hold_done = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed headers:
      //   end-of-contents marker, broken marker,
      //   private constructed tag 30 with short length 127,
      //   application primitive tag with indefinite length,
      //   universal tag 2 with four length octets all ones,
      //   length octet count above the limit,
      //   longest legal tag (all ones) with length 0,
      //   tag too long made of 0x80 extension octets.
      hdr_bytes = '{8'h00, 8'h00,
                    8'h00, 8'h5a,
                    8'hfe, 8'h7f,
                    8'h41, 8'h80,
                    8'h02, 8'h84, 8'hff, 8'hff, 8'hff, 8'hff,
                    8'h30, 8'h85,
                    8'h9f, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h00,
                    8'h1f, 8'h80, 8'h80, 8'h80, 8'h80};
      while (hdr_bytes.size() > 0) send_octet(hdr_bytes.pop_front());

      // Random part: rotate idling modes so gaps land on every decode phase,
      // with some stretches running flat out.
      while (octets_sent < TOTAL_OCTETS) begin
         sec = (octets_sent / SECTION_LEN) % 4;
         case (sec)
            0: begin req_gap_max = 10; rsp_gap_max = 10; end
            1: begin req_gap_max = 0;  rsp_gap_max = 0;  end
            2: begin req_gap_max = 0;  rsp_gap_max = 10; end
            default: begin req_gap_max = 10; rsp_gap_max = 0; end
         endcase
         if (!hold_done && octets_sent >= HOLD_AT) begin
            hold_rsp  = 1'b1;
            hold_done = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) begin
            // noise: raw octets that may cut into or shift a header
            for (i = $urandom_range(1, 6); i > 0; i--)
               hdr_bytes.push_back(8'($urandom));
         end else begin
            push_header();
         end
         while (hdr_bytes.size() > 0) send_octet(hdr_bytes.pop_front());
      end
      req_tvalid <= 1'b0;

      // let the checker see the last octet, then drain the results
      @(posedge clock);
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d header octets (directed and random, noise mixed in)",
               octets_sent);
      $display("and %0d results, %0d of them error reports, with a %0d-cycle stall",
               rsp_count, err_count, HOLD_CYCLES);
      if (fail_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d results never arrived", fail_count, pending_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> files.f
src/btlv_pkg.sv
src/btlv_input_stage.sv
src/btlv_decoder.sv
src/btlv_result_stage.sv
src/ber_tlv_header_parser.sv
bench/ber_header_checker.sv
bench/ber_tlv_header_parser_tb.sv
